@@ rtl/acl_pkg.sv @@
// ----------------------------------------------------------------------------
// ACL classifier package
// Shared constants, result codes and record types of the five-tuple classifier.
// ----------------------------------------------------------------------------
package acl_pkg;

	localparam int RULE_DEPTH_DEF = 64;
	localparam int LIST_COUNT     = 8;

	localparam int LIST_W  = 3;
	localparam int ADDR_W  = 32;
	localparam int PROTO_W = 8;
	localparam int PORT_W  = 16;
	localparam int WILD_W  = 5;
	localparam int PRIO_W  = 8;
	localparam int ACT_W   = 8;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = 6;
	localparam int MASK_W  = 8;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_LIST  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_MATCH    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_MATCH = 3'd4;

	localparam int WB_SADDR = 0;
	localparam int WB_DADDR = 1;
	localparam int WB_PROTO = 2;
	localparam int WB_SPORT = 3;
	localparam int WB_DPORT = 4;

	typedef struct packed {
		logic [LIST_W-1:0]  list_id;
		logic [ADDR_W-1:0]  source_address;
		logic [ADDR_W-1:0]  dest_address;
		logic [PROTO_W-1:0] proto_number;
		logic [PORT_W-1:0]  source_port_num;
		logic [PORT_W-1:0]  dest_port_num;
		logic [WILD_W-1:0]  wildcard_bits;
		logic [PRIO_W-1:0]  rule_priority;
		logic [ACT_W-1:0]   rule_action;
	} rule_t;

	typedef struct packed {
		logic  opcode;
		rule_t rule;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ACT_W-1:0]  match_action;
		logic [PRIO_W-1:0] match_priority;
		logic [IDX_W-1:0]  match_index;
	} result_t;

	typedef struct packed {
		logic load;
		logic start_scan;
		logic issue;
		logic capture;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_check;
		logic list_on;
		logic scan_end;
		logic hit;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/acl_if.sv @@
// ----------------------------------------------------------------------------
// ACL classifier channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface acl_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [acl_pkg::LIST_W-1:0]  list_id;
	logic [acl_pkg::ADDR_W-1:0]  source_address;
	logic [acl_pkg::ADDR_W-1:0]  dest_address;
	logic [acl_pkg::PROTO_W-1:0] proto_number;
	logic [acl_pkg::PORT_W-1:0]  source_port_num;
	logic [acl_pkg::PORT_W-1:0]  dest_port_num;
	logic [acl_pkg::WILD_W-1:0]  wildcard_bits;
	logic [acl_pkg::PRIO_W-1:0]  rule_priority;
	logic [acl_pkg::ACT_W-1:0]   rule_action;

	modport source (
		output valid, opcode, list_id, source_address, dest_address, proto_number,
			source_port_num, dest_port_num, wildcard_bits, rule_priority, rule_action,
		input ready
	);
	modport sink (
		input valid, opcode, list_id, source_address, dest_address, proto_number,
			source_port_num, dest_port_num, wildcard_bits, rule_priority, rule_action,
		output ready
	);
endinterface

interface acl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [acl_pkg::STAT_W-1:0] status;
	logic [acl_pkg::ACT_W-1:0]  match_action;
	logic [acl_pkg::PRIO_W-1:0] match_priority;
	logic [acl_pkg::IDX_W-1:0]  match_index;

	modport source (
		output valid, status, match_action, match_priority, match_index,
		input ready
	);
	modport sink (
		input valid, status, match_action, match_priority, match_index,
		output ready
	);
endinterface

@@ rtl/acl_ram.sv @@
// ----------------------------------------------------------------------------
// ACL generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module acl_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/acl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ACL classifier controller
// Sequences decode, table scan, result capture and response transfer.
// ----------------------------------------------------------------------------
module acl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  acl_pkg::stat_t stat,
	output acl_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_check && stat.list_on) begin
					cmd.start_scan = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.capture = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_SCAN: begin
				if (stat.hit || stat.scan_end) begin
					cmd.capture = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/acl_dp.sv @@
// ----------------------------------------------------------------------------
// ACL classifier datapath
// Holds the rule table, rule count, current item, scan pointer and response.
// ----------------------------------------------------------------------------
module acl_dp #(
	parameter int RULE_DEPTH = acl_pkg::RULE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [acl_pkg::MASK_W-1:0]  cfg_wr_data,
	input  acl_pkg::item_t              item,
	input  acl_pkg::cmd_t               cmd,
	output acl_pkg::stat_t              stat,
	input  logic                        out_ready,
	output logic                        out_valid,
	output acl_pkg::result_t            out_res
);

	localparam int AW = $clog2(RULE_DEPTH);
	localparam int CW = $clog2(RULE_DEPTH + 1);

	logic [acl_pkg::MASK_W-1:0] mask_q;
	acl_pkg::item_t             item_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              addr_q;
	logic                       rd_pend_s1;
	logic [AW-1:0]              rd_idx_s1;
	acl_pkg::rule_t             rd_rule;
	acl_pkg::result_t           res;
	acl_pkg::result_t           res_q;
	logic                       out_valid_q;
	logic                       list_on;
	logic                       full;
	logic                       hit;
	logic                       add_ok;

	acl_ram #(
		.WIDTH($bits(acl_pkg::rule_t)),
		.DEPTH(RULE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (add_ok),
		.waddr(cnt_q[AW-1:0]),
		.wdata(item_q.rule),
		.re   (cmd.issue),
		.raddr(addr_q[AW-1:0]),
		.rdata(rd_rule)
	);

	assign list_on = (int'(item_q.rule.list_id) < acl_pkg::LIST_COUNT) &&
		mask_q[item_q.rule.list_id];
	assign full    = (cnt_q == CW'(RULE_DEPTH));
	assign add_ok  = cmd.capture && (item_q.opcode == acl_pkg::OP_ADD) && list_on && !full;

	always_comb begin
		hit = rd_pend_s1 && (rd_rule.list_id == item_q.rule.list_id);
		if (!rd_rule.wildcard_bits[acl_pkg::WB_SADDR] &&
			rd_rule.source_address != item_q.rule.source_address) begin
			hit = 1'b0;
		end
		if (!rd_rule.wildcard_bits[acl_pkg::WB_DADDR] &&
			rd_rule.dest_address != item_q.rule.dest_address) begin
			hit = 1'b0;
		end
		if (!rd_rule.wildcard_bits[acl_pkg::WB_PROTO] &&
			rd_rule.proto_number != item_q.rule.proto_number) begin
			hit = 1'b0;
		end
		if (!rd_rule.wildcard_bits[acl_pkg::WB_SPORT] &&
			rd_rule.source_port_num != item_q.rule.source_port_num) begin
			hit = 1'b0;
		end
		if (!rd_rule.wildcard_bits[acl_pkg::WB_DPORT] &&
			rd_rule.dest_port_num != item_q.rule.dest_port_num) begin
			hit = 1'b0;
		end
	end

	always_comb begin
		res = '0;
		if (item_q.opcode == acl_pkg::OP_ADD) begin
			if (!list_on) begin
				res.status = acl_pkg::ST_NO_LIST;
			end else if (full) begin
				res.status = acl_pkg::ST_FULL;
			end else begin
				res.status      = acl_pkg::ST_ADDED;
				res.match_index = acl_pkg::IDX_W'(cnt_q);
			end
		end else if (hit) begin
			res.status         = acl_pkg::ST_MATCH;
			res.match_action   = rd_rule.rule_action;
			res.match_priority = rd_rule.rule_priority;
			res.match_index    = acl_pkg::IDX_W'(rd_idx_s1);
		end else begin
			res.status = acl_pkg::ST_NO_MATCH;
		end
	end

	assign stat.is_check = (item_q.opcode == acl_pkg::OP_CHECK);
	assign stat.list_on  = list_on;
	assign stat.scan_end = (addr_q >= cnt_q);
	assign stat.hit      = hit;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			cnt_q       <= '0;
			addr_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mask_q <= cfg_wr_data;
			end
			if (add_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.start_scan) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + CW'(1);
			end
			rd_pend_s1 <= cmd.issue;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.issue) begin
			rd_idx_s1 <= addr_q[AW-1:0];
		end
		if (cmd.capture) begin
			res_q <= res;
		end
		if (cmd.finish) begin
			out_res <= res_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/acl_five_tuple_classifier.sv @@
// ----------------------------------------------------------------------------
// Five-tuple ACL classifier, first match wins
// Appends rules to an insertion-ordered table and looks up packets in it.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer when           Carries
//  req      sink       req.valid & req.ready   add-rule or check item
//  rsp      source     rsp.valid & rsp.ready   status, action, priority, index
//  cfg      write      cfg_wr_en               list_enabled_mask
//
// One item is in work at a time; req.ready is high only while the controller is idle.
// An add, or a check on a list that is not enabled, is captured straight after decode.
// Other checks read one rule per cycle from the registered RAM, up to the first match
// or the last rule, and are then captured.
// req.ready rises with the response, so the next item can be taken while it waits.
// A waiting response holds only the next item; reset clears the count, mask and control.
// ----------------------------------------------------------------------------
module acl_five_tuple_classifier #(
	parameter int RULE_DEPTH = acl_pkg::RULE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [acl_pkg::MASK_W-1:0] cfg_wr_data,
	acl_req_if.sink                    req,
	acl_rsp_if.source                  rsp
);

	acl_pkg::cmd_t    cmd;
	acl_pkg::stat_t   stat;
	acl_pkg::item_t   item;
	acl_pkg::result_t res;

	assign item.opcode               = req.opcode;
	assign item.rule.list_id         = req.list_id;
	assign item.rule.source_address  = req.source_address;
	assign item.rule.dest_address    = req.dest_address;
	assign item.rule.proto_number    = req.proto_number;
	assign item.rule.source_port_num = req.source_port_num;
	assign item.rule.dest_port_num   = req.dest_port_num;
	assign item.rule.wildcard_bits   = req.wildcard_bits;
	assign item.rule.rule_priority   = req.rule_priority;
	assign item.rule.rule_action     = req.rule_action;

	acl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acl_dp #(
		.RULE_DEPTH(RULE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_res    (res)
	);

	assign rsp.status         = res.status;
	assign rsp.match_action   = res.match_action;
	assign rsp.match_priority = res.match_priority;
	assign rsp.match_index    = res.match_index;

endmodule

@@ rtl/acl_chk.sv @@
// ----------------------------------------------------------------------------
// ACL classifier port checker
// Checks handshake and response consistency at the top-level ports.
// ----------------------------------------------------------------------------
module acl_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [acl_pkg::STAT_W-1:0] status,
	input logic [acl_pkg::ACT_W-1:0]  match_action,
	input logic [acl_pkg::PRIO_W-1:0] match_priority,
	input logic [acl_pkg::IDX_W-1:0]  match_index
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Response valid dropped before its transfer.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request accepted while an item is in work.");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != acl_pkg::ST_MATCH) |->
			(match_action == '0) && (match_priority == '0))
		else $error("Action or priority set without a match.");

	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == acl_pkg::ST_NO_LIST || status == acl_pkg::ST_FULL ||
			status == acl_pkg::ST_NO_MATCH) |-> (match_index == '0))
		else $error("Index set on a failed add or a missed lookup.");

endmodule

bind acl_five_tuple_classifier acl_chk u_acl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.match_action  (rsp.match_action),
	.match_priority(rsp.match_priority),
	.match_index   (rsp.match_index)
);

@@ sim/acl_response_checker.sv @@
// ----------------------------------------------------------------------------
// ACL classifier response checker
// Watches the request, response and list mask write ports of the classifier.
// It keeps its own copy of the rule table and the list mask, and it works out
// the response to every request transfer. Each response transfer is then
// compared field by field with the oldest expected response.
// ----------------------------------------------------------------------------
module acl_response_checker
	import acl_pkg::*;
#(
	parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MASK_W-1:0] cfg_wr_data,
	acl_req_if                req,
	acl_rsp_if                rsp,
	output int                outstanding,
	output int                mismatches
);

	localparam int PRINT_LIMIT = 40;

	rule_t             rule_table [RULE_DEPTH];
	int                rules_used;
	logic [MASK_W-1:0] list_mask;
	result_t           expected_responses [$];
	result_t           oldest;
	item_t             accepted_item;
	int                responses_seen;

	initial mismatches = 0;

	task automatic report_mismatch(string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("response %0d %s is %0h, expected %0h",
				responses_seen, name, got, want));
	endtask

	function automatic bit rule_fires(rule_t r, item_t pkt);
		return (r.wildcard_bits[WB_SADDR] || r.source_address == pkt.rule.source_address)
			&& (r.wildcard_bits[WB_DADDR] || r.dest_address == pkt.rule.dest_address)
			&& (r.wildcard_bits[WB_PROTO] || r.proto_number == pkt.rule.proto_number)
			&& (r.wildcard_bits[WB_SPORT] || r.source_port_num == pkt.rule.source_port_num)
			&& (r.wildcard_bits[WB_DPORT] || r.dest_port_num == pkt.rule.dest_port_num);
	endfunction

	// Adds update the rule table, so this must run once per request transfer.
	function automatic result_t acl_response_for(item_t it);
		result_t res;
		logic    enabled;
		bit      found;
		int      i;
		res = '0;
		res.status = ST_NO_MATCH;
		found = 1'b0;
		enabled = (int'(it.rule.list_id) < LIST_COUNT) && list_mask[it.rule.list_id];
		if (it.opcode == OP_ADD) begin
			if (!enabled) begin
				res.status = ST_NO_LIST;
			end else if (rules_used >= RULE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				rule_table[rules_used] = it.rule;
				res.status = ST_ADDED;
				res.match_index = IDX_W'(rules_used);
				rules_used++;
			end
		end else if (enabled) begin
			for (i = 0; i < rules_used && !found; i++) begin
				if (rule_table[i].list_id == it.rule.list_id && rule_fires(rule_table[i], it)) begin
					found = 1'b1;
					res.status = ST_MATCH;
					res.match_action = rule_table[i].rule_action;
					res.match_priority = rule_table[i].rule_priority;
					res.match_index = IDX_W'(i);
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_used = 0;
			list_mask = '0;
			responses_seen = 0;
			expected_responses.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				list_mask = cfg_wr_data;
			if (req.valid && req.ready) begin
				accepted_item = {req.opcode, req.list_id, req.source_address, req.dest_address,
					req.proto_number, req.source_port_num, req.dest_port_num,
					req.wildcard_bits, req.rule_priority, req.rule_action};
				expected_responses.push_back(acl_response_for(accepted_item));
			end
			if (rsp.valid && rsp.ready) begin
				responses_seen++;
				if (expected_responses.size() == 0) begin
					report_mismatch($sformatf("response %0d arrived with none expected",
						responses_seen));
				end else begin
					oldest = expected_responses.pop_front();
					check_field("status", 32'(rsp.status), 32'(oldest.status));
					check_field("match_action", 32'(rsp.match_action),
						32'(oldest.match_action));
					check_field("match_priority", 32'(rsp.match_priority),
						32'(oldest.match_priority));
					check_field("match_index", 32'(rsp.match_index),
						32'(oldest.match_index));
				end
			end
			outstanding <= expected_responses.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// ACL classifier testbench
// Drives add-rule and check items into the five-tuple classifier through a
// directed part and a series of random phases, each under its own list mask.
// The response checker beside the block predicts and compares every transfer;
// this module makes the stimulus, the response back-pressure and the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import acl_pkg::*;

	localparam int RULE_DEPTH      = RULE_DEPTH_DEF;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int ADD_PERCENT     = 35;
	localparam int IDLE_PERCENT    = 29;
	localparam int RSP_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int QUIET_LIMIT     = 4000;

	localparam logic [ADDR_W-1:0] B_SA = 32'h0A00_0001;
	localparam logic [ADDR_W-1:0] B_DA = 32'hC0A8_0001;
	localparam int                B_PR = 6;
	localparam int                B_SP = 1234;
	localparam int                B_DP = 80;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [MASK_W-1:0] cfg_wr_data;
	int                outstanding;
	int                mismatches;
	int                quiet_cycles = 0;
	int                hold_token = 0;
	bit                steady = 1'b0;
	item_t             sent_rules [$];

	acl_req_if req_if ();
	acl_rsp_if rsp_if ();

	acl_five_tuple_classifier #(
		.RULE_DEPTH(RULE_DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_if),
		.rsp        (rsp_if)
	);

	acl_response_checker #(
		.RULE_DEPTH(RULE_DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_if),
		.rsp        (rsp_if),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Response side: random back-pressure, plus one long hold-off per token.
	initial begin
		int hold_seen;
		hold_seen = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				rsp_if.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_item(logic op, int list, logic [ADDR_W-1:0] sa,
			logic [ADDR_W-1:0] da, int pr, int sp, int dp, int wb, int pri, int act);
		item_t it;
		it.opcode = op;
		it.rule.list_id = LIST_W'(list);
		it.rule.source_address = sa;
		it.rule.dest_address = da;
		it.rule.proto_number = PROTO_W'(pr);
		it.rule.source_port_num = PORT_W'(sp);
		it.rule.dest_port_num = PORT_W'(dp);
		it.rule.wildcard_bits = WILD_W'(wb);
		it.rule.rule_priority = PRIO_W'(pri);
		it.rule.rule_action = ACT_W'(act);
		return it;
	endfunction

	// Field values come mostly from small pools so that rules and packets collide.
	function automatic logic [ADDR_W-1:0] pool_addr();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return B_SA;
			3: return B_DA;
			default: return $urandom();
		endcase
	endfunction

	function automatic int pool_port();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 65535;
			2: return 80;
			3: return 443;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pool_proto();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 255;
			2: return 6;
			3: return 17;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic item_t random_item(logic op);
		return make_item(op, $urandom_range(0, LIST_COUNT - 1), pool_addr(), pool_addr(),
			pool_proto(), pool_port(), pool_port(), $urandom_range(0, 31),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	// Most checks reuse the tuple of an earlier add with a few fields changed.
	function automatic item_t derive_check();
		item_t it;
		item_t fresh;
		fresh = random_item(OP_CHECK);
		if (sent_rules.size() == 0 || $urandom_range(0, 3) == 0)
			return fresh;
		it = sent_rules[$urandom_range(0, sent_rules.size() - 1)];
		it.opcode = OP_CHECK;
		if ($urandom_range(0, 9) == 0)
			it.rule.list_id = fresh.rule.list_id;
		if ($urandom_range(0, 4) == 0)
			it.rule.source_address = fresh.rule.source_address;
		if ($urandom_range(0, 4) == 0)
			it.rule.dest_address = fresh.rule.dest_address;
		if ($urandom_range(0, 4) == 0)
			it.rule.proto_number = fresh.rule.proto_number;
		if ($urandom_range(0, 4) == 0)
			it.rule.source_port_num = fresh.rule.source_port_num;
		if ($urandom_range(0, 4) == 0)
			it.rule.dest_port_num = fresh.rule.dest_port_num;
		it.rule.wildcard_bits = fresh.rule.wildcard_bits;
		it.rule.rule_priority = fresh.rule.rule_priority;
		it.rule.rule_action = fresh.rule.rule_action;
		return it;
	endfunction

	task automatic send_item(item_t it);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		{req_if.opcode, req_if.list_id, req_if.source_address, req_if.dest_address,
			req_if.proto_number, req_if.source_port_num, req_if.dest_port_num,
			req_if.wildcard_bits, req_if.rule_priority, req_if.rule_action} <= it;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
		if (it.opcode == OP_ADD)
			sent_rules.push_back(it);
	endtask

	task automatic wait_for_responses();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic change_list_mask(logic [MASK_W-1:0] mask);
		wait_for_responses();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mask;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		item_t             it;
		logic [MASK_W-1:0] mask;
		int                phase;
		int                n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_if.valid = 1'b0;
		{req_if.opcode, req_if.list_id, req_if.source_address, req_if.dest_address,
			req_if.proto_number, req_if.source_port_num, req_if.dest_port_num,
			req_if.wildcard_bits, req_if.rule_priority, req_if.rule_action} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no list enabled, an add is refused and a check finds nothing.
		send_item(make_item(OP_ADD, 3, B_SA, B_DA, B_PR, B_SP, B_DP, 0, 1, 2));
		send_item(make_item(OP_CHECK, 1, '0, '0, 0, 0, 0, 0, 0, 0));

		change_list_mask(8'hFF);
		send_item(make_item(OP_ADD, 0, '0, '0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_ADD, 7, '1, '1, 255, 65535, 65535, 0, 255, 255));
		send_item(make_item(OP_ADD, 5, $urandom(), $urandom(), 17, 443, 53, 31, 'h5A, 'hA5));
		for (n = 0; n < WILD_W; n++)
			send_item(make_item(OP_ADD, 2, B_SA, B_DA, B_PR, B_SP, B_DP, 1 << n, 16 + n, 32 + n));
		send_item(make_item(OP_CHECK, 0, '0, '0, 0, 0, 0, 31, 255, 255));
		send_item(make_item(OP_CHECK, 7, '1, '1, 255, 65535, 65535, 0, 0, 0));
		send_item(make_item(OP_CHECK, 0, '1, '1, 255, 65535, 65535, 0, 0, 0));
		send_item(make_item(OP_CHECK, 5, $urandom(), $urandom(), $urandom_range(0, 255),
			$urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0, 0));
		// Each packet differs from the base tuple in one field, so only the rule
		// that leaves that field open can match.
		for (n = 0; n < WILD_W; n++) begin
			it = make_item(OP_CHECK, 2, B_SA, B_DA, B_PR, B_SP, B_DP, 0, 0, 0);
			case (n)
				WB_SADDR: it.rule.source_address = ~B_SA;
				WB_DADDR: it.rule.dest_address = ~B_DA;
				WB_PROTO: it.rule.proto_number = 8'hF9;
				WB_SPORT: it.rule.source_port_num = 16'hFFFF;
				default:  it.rule.dest_port_num = 16'h0000;
			endcase
			send_item(it);
		end
		send_item(make_item(OP_CHECK, 4, B_SA, B_DA, B_PR, B_SP, B_DP, 0, 0, 0));

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0, 6:    mask = 8'hFF;
				1:       mask = 8'h55;
				2:       mask = 8'hAA;
				4:       mask = 8'h0F;
				5:       mask = 8'h00;
				default: mask = MASK_W'($urandom_range(1, 254));
			endcase
			change_list_mask(mask);
			steady <= (phase == 2);
			if (phase == 1 || phase == 6)
				hold_token <= hold_token + 1;
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(($urandom_range(0, 99) < ADD_PERCENT) ? random_item(OP_ADD)
					: derive_check());
		end

		wait_for_responses();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ acl_five_tuple_classifier.f @@
rtl/acl_pkg.sv
rtl/acl_if.sv
rtl/acl_ram.sv
rtl/acl_ctrl.sv
rtl/acl_dp.sv
rtl/acl_five_tuple_classifier.sv
rtl/acl_chk.sv
sim/acl_response_checker.sv
sim/testbench.sv
